@@ design/prime_sieve_filter_chain_macros.svh @@
// assertion macros shared by the prime sieve checker
`ifndef PRIME_SIEVE_FILTER_CHAIN_MACROS_SVH
`define PRIME_SIEVE_FILTER_CHAIN_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prime sieve check failed");

// next-cycle implication, sampled on clk, off during reset
`define PSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prime sieve check failed");

`endif

@@ design/psf_pkg.sv @@
// shared constants and types for the prime sieve filter chain
`timescale 1ns / 1ps
`default_nettype none

package psf_pkg;

    // width of the candidate and result ports
    localparam int FIELD_BITS = 16;
    // width of the values held and tested in the chain
    localparam int VALUE_BITS = 16;
    // number of filter cells
    localparam int NUM_STAGES = 16;

    // bit counter for the serial candidate stream
    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

    // one slot moving down the chain per cycle while the chain advances
    typedef struct packed {
        logic valid;   // slot carries data
        logic dbit;    // candidate bit, msb first
        logic first;   // first bit of a candidate
        logic last;    // last bit of a candidate, or a clear slot
        logic clr;     // clear all cells
        logic alive;   // candidate not yet divided out
        logic stored;  // candidate already stored in a cell
    } slot_t;

endpackage

`default_nettype wire

@@ design/psf_launch.sv @@
// input stage: takes requests and streams candidate bits into the chain
`timescale 1ns / 1ps
`default_nettype none

module psf_launch import psf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [FIELD_BITS-1:0] candidate,
    input  wire logic                  restart,
    input  wire logic                  advance,
    output slot_t                      slot_out
);

    logic                  busy_reg, busy_next;
    logic                  clr_reg, clr_next;
    logic [VALUE_BITS-1:0] sh_reg, sh_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] cand_m;
    logic                  ready;
    logic                  accept;

    // slot driven into the first cell
    always_comb
    begin
        slot_out.valid  = busy_reg;
        slot_out.dbit   = sh_reg[VALUE_BITS-1];
        slot_out.first  = (cnt_reg == '0);
        slot_out.last   = clr_reg || (cnt_reg == CNT_LAST);
        slot_out.clr    = clr_reg;
        slot_out.alive  = 1'b1;
        slot_out.stored = 1'b0;
    end

    // a new request is taken once the current one sends its last slot
    assign cand_m   = VALUE_BITS'(candidate);
    assign ready    = !busy_reg || (advance && slot_out.last);
    assign in_stall = !ready;
    assign accept   = in_valid && ready;

    // serializer next state
    always_comb
    begin
        busy_next = busy_reg;
        clr_next  = clr_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        if (advance && busy_reg)
        begin
            if (slot_out.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                sh_next  = {sh_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_BITS'(1);
            end
        end
        if (accept)
        begin
            if (restart)
            begin
                busy_next = 1'b1;
                clr_next  = 1'b1;
                cnt_next  = '0;
            end
            else if (cand_m >= VALUE_BITS'(2))
            begin
                busy_next = 1'b1;
                clr_next  = 1'b0;
                sh_next   = cand_m;
                cnt_next  = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            clr_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            clr_reg  <= clr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // candidate shift register
    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

endmodule

`default_nettype wire

@@ design/psf_cell.sv @@
// one filter cell: holds a prime and divides the passing candidate bit-serially
`timescale 1ns / 1ps
`default_nettype none

module psf_cell import psf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire slot_t slot_in,
    output slot_t      slot_out
);

    logic                  filled_reg, filled_next;
    logic [VALUE_BITS-1:0] prime_reg, prime_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    slot_t                 slot_reg, slot_next;
    logic [VALUE_BITS-1:0] base;
    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS+1:0] diff;
    logic                  ge;
    logic                  div;

    // one restoring division step, or a plain shift when the cell is empty
    always_comb
    begin
        base    = slot_in.first ? '0 : rem_reg;
        shifted = {base, slot_in.dbit};
        diff    = {1'b0, shifted} - {2'b00, prime_reg};
        ge      = !diff[VALUE_BITS+1];
        if (filled_reg && ge)
        begin
            rem_next = diff[VALUE_BITS-1:0];
        end
        else
        begin
            rem_next = shifted[VALUE_BITS-1:0];
        end
        div = filled_reg && (rem_next == '0);
    end

    // decision at the end of a candidate, clear on a clear slot
    always_comb
    begin
        slot_next   = slot_in;
        filled_next = filled_reg;
        prime_next  = prime_reg;
        if (slot_in.valid && slot_in.clr)
        begin
            filled_next = 1'b0;
        end
        else if (slot_in.valid && slot_in.last)
        begin
            if (div)
            begin
                slot_next.alive = 1'b0;
            end
            else if (!filled_reg && slot_in.alive)
            begin
                prime_next       = rem_next;
                filled_next      = 1'b1;
                slot_next.alive  = 1'b0;
                slot_next.stored = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            slot_reg   <= '0;
        end
        else if (advance)
        begin
            filled_reg <= filled_next;
            slot_reg   <= slot_next;
        end
    end

    // prime and partial remainder
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prime_reg <= prime_next;
            if (slot_in.valid)
            begin
                rem_reg <= rem_next;
            end
        end
    end

    assign slot_out = slot_reg;

endmodule

`default_nettype wire

@@ design/psf_collect.sv @@
// chain tail: rebuilds the candidate and holds the result for the receiver
`timescale 1ns / 1ps
`default_nettype none

module psf_collect import psf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire slot_t                 slot_in,
    output logic                       advance,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [FIELD_BITS-1:0]      found_prime,
    output logic                       overflow
);

    logic [VALUE_BITS-1:0] coll_reg, coll_next;
    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] found_prime_reg, found_prime_next;
    logic                  overflow_reg, overflow_next;
    logic                  has_result;

    // a finished candidate that was stored or ran past every cell
    assign coll_next  = {coll_reg[VALUE_BITS-2:0], slot_in.dbit};
    assign has_result = slot_in.valid && slot_in.last && !slot_in.clr
                        && (slot_in.alive || slot_in.stored);

    // the whole chain holds only while a result waits on a stalled receiver
    assign advance = !(has_result && out_valid_reg && out_stall);

    // output register next state
    always_comb
    begin
        out_valid_next   = out_valid_reg && out_stall;
        found_prime_next = found_prime_reg;
        overflow_next    = overflow_reg;
        if (advance && has_result)
        begin
            out_valid_next   = 1'b1;
            found_prime_next = slot_in.stored ? FIELD_BITS'(coll_next) : '0;
            overflow_next    = !slot_in.stored;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        found_prime_reg <= found_prime_next;
        overflow_reg    <= overflow_next;
        if (advance && slot_in.valid)
        begin
            coll_reg <= coll_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found_prime = found_prime_reg;
    assign overflow    = overflow_reg;

endmodule

`default_nettype wire

@@ design/prime_sieve_filter_chain.sv @@
// top level of the prime sieve filter chain
// Usage:
//   Input channel (in_valid / in_stall) takes one request: candidate and restart.
//   A candidate is streamed msb first through a row of NUM_STAGES filter cells,
//   one bit per cycle while the row advances; each filled cell reduces it by
//   its prime bit-serially. The first empty cell stores a survivor; a survivor
//   past a full row overflows. Output channel (out_valid / out_stall) gives
//   found_prime, or overflow = 1. The next candidate follows its predecessor's
//   bits straight away: the input takes a new request as the last bit goes out.
//   A restart request sends a single clear slot; a candidate below two is
//   taken but sends no slot and gives no result. From the accepting edge to
//   out_valid a candidate passes the serializer's shifts of the bit stream,
//   one register per cell and the output register.
//   Restart travels down the row as a clear slot and gives no result.
//   Reset empties every cell and the output register.
//   When the receiver stalls with a result waiting and another result reaches
//   the end of the row, the whole row holds until the waiting one is taken.
`timescale 1ns / 1ps
`default_nettype none

module prime_sieve_filter_chain import psf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [FIELD_BITS-1:0] candidate,
    input  wire logic                  restart,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [FIELD_BITS-1:0]      found_prime,
    output logic                       overflow
);

    slot_t links [NUM_STAGES+1];
    logic  advance;

    // serializer
    psf_launch u_launch (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .candidate(candidate),
        .restart  (restart),
        .advance  (advance),
        .slot_out (links[0])
    );

    // row of filter cells
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_cell
        psf_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .slot_in (links[g]),
            .slot_out(links[g+1])
        );
    end

    // tail and output register
    psf_collect u_collect (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_in    (links[NUM_STAGES]),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found_prime(found_prime),
        .overflow   (overflow)
    );

endmodule

`default_nettype wire

@@ design/psf_checker.sv @@
// port-level checker for the prime sieve filter chain, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "prime_sieve_filter_chain_macros.svh"

module psf_checker import psf_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [FIELD_BITS-1:0] found_prime,
    input wire logic                  overflow
);

    // a waiting result is not withdrawn
    `PSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // a waiting result keeps its value
    `PSF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(found_prime) && $stable(overflow))
    // overflow results carry no prime, prime results carry one
    `PSF_ASSERT_SAME(a_kind, out_valid, overflow == (found_prime == '0))
    // a reported prime is never below two
    `PSF_ASSERT_SAME(a_min, out_valid && !overflow, found_prime >= FIELD_BITS'(2))

endmodule

bind prime_sieve_filter_chain psf_checker u_checker (.*);

`default_nettype wire
